// ----- rtl/mexp_pkg.sv -----
package mexp_pkg;

  // Width of every payload port
  localparam int FIELD_W = 64;

  // Default operand width used inside the block
  localparam int WIDTH_DEFAULT = 64;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_RED  = 5'b00010,
    S_CHK  = 5'b00100,
    S_MUL  = 5'b01000,
    S_SQR  = 5'b10000
  } state_t;

endpackage

// ----- rtl/modular_exponentiation.sv -----
// Modular exponentiation, right-to-left binary method. Pulse start while busy is low to
// hand in one word (base, exponent, modulus). Exactly one result word comes back on
// out_power_result / out_modulus_error, shown for a single cycle with out_valid high.
// The receiver cannot stall it, so capture it on that cycle. Only the low WIDTH bits of
// each input are used, and the result is zero-extended to 64 bits. A zero modulus gives
// result 0 with out_modulus_error set, in the cycle after start. A zero exponent gives 1,
// even for a modulus of 1. Every modular product runs on one shared bit-serial
// double-and-add unit. That unit consumes one multiplier bit per cycle. The base is
// first reduced. Then each exponent bit up to the highest set bit gets a decision step,
// then a multiply into the accumulator when the bit is set, and then a squaring.
// busy stays high for the whole run.
module modular_exponentiation #(
  parameter int WIDTH = mexp_pkg::WIDTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [63:0] in_base_value,
  input  logic [63:0] in_exponent_value,
  input  logic [63:0] in_modulus_value,
  output logic        out_valid,
  output logic [63:0] out_power_result,
  output logic        out_modulus_error
);

  localparam int FW = mexp_pkg::FIELD_W;
  localparam int CW = $clog2(WIDTH);
  localparam int TW = WIDTH + 2;

  mexp_pkg::state_t state_r, state_nxt;

  logic [WIDTH-1:0] m_r, m_nxt;      // modulus
  logic [WIDTH-1:0] sq_r, sq_nxt;    // running square
  logic [WIDTH-1:0] acc_r, acc_nxt;  // accumulator
  logic [WIDTH-1:0] exp_r, exp_nxt;  // exponent, shifted right per bit
  logic [WIDTH-1:0] p_r, p_nxt;      // product being formed
  logic [WIDTH-1:0] y_r, y_nxt;      // multiplier, shifted out MSB first
  logic [CW-1:0]    cnt_r, cnt_nxt;  // multiplier bits left after this one

  logic             out_valid_r, out_valid_nxt;
  logic [FW-1:0]    res_r, res_nxt;
  logic             err_r, err_nxt;

  logic             accept;
  logic [WIDTH-1:0] x_op;
  logic [TW-1:0]    t_sum;
  logic [TW-1:0]    t_m1;
  logic [TW-1:0]    t_m2;
  logic [TW-1:0]    t_red;
  logic [WIDTH-1:0] step_p;

  assign accept = start && !busy;

  // Multiplicand: 1 while reducing the base (Horner over the base bits), else the square.
  assign x_op = (state_r == mexp_pkg::S_RED) ? WIDTH'(1) : sq_r;

  // One double-and-add step: 2p + bit*x stays below 3m since p < m and x <= m.
  // Drop m or 2m to bring it back under m.
  always_comb begin
    t_sum = {1'b0, p_r, 1'b0} + (y_r[WIDTH-1] ? {2'b00, x_op} : '0);
    t_m1  = {2'b00, m_r};
    t_m2  = {1'b0, m_r, 1'b0};
    if (t_sum >= t_m2) begin
      t_red = t_sum - t_m2;
    end else if (t_sum >= t_m1) begin
      t_red = t_sum - t_m1;
    end else begin
      t_red = t_sum;
    end
    step_p = t_red[WIDTH-1:0];
  end

  always_comb begin
    state_nxt     = state_r;
    m_nxt         = m_r;
    sq_nxt        = sq_r;
    acc_nxt       = acc_r;
    exp_nxt       = exp_r;
    p_nxt         = p_r;
    y_nxt         = y_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = 1'b0;
    res_nxt       = res_r;
    err_nxt       = err_r;

    unique case (state_r)
      mexp_pkg::S_IDLE: begin
        if (accept) begin
          m_nxt   = in_modulus_value[WIDTH-1:0];
          exp_nxt = in_exponent_value[WIDTH-1:0];
          acc_nxt = WIDTH'(1);
          p_nxt   = '0;
          y_nxt   = in_base_value[WIDTH-1:0];
          cnt_nxt = CW'(WIDTH - 1);
          if (in_modulus_value[WIDTH-1:0] == '0) begin
            // Zero modulus: answer at once with the error flag.
            out_valid_nxt = 1'b1;
            res_nxt       = '0;
            err_nxt       = 1'b1;
          end else begin
            state_nxt = mexp_pkg::S_RED;
          end
        end
      end

      mexp_pkg::S_RED: begin
        p_nxt   = step_p;
        y_nxt   = {y_r[WIDTH-2:0], 1'b0};
        cnt_nxt = cnt_r - CW'(1);
        if (cnt_r == '0) begin
          sq_nxt    = step_p;
          state_nxt = mexp_pkg::S_CHK;
        end
      end

      mexp_pkg::S_CHK: begin
        p_nxt   = '0;
        cnt_nxt = CW'(WIDTH - 1);
        if (exp_r == '0) begin
          // No set bits left: release the accumulator.
          out_valid_nxt = 1'b1;
          res_nxt       = FW'(acc_r);
          err_nxt       = 1'b0;
          state_nxt     = mexp_pkg::S_IDLE;
        end else if (exp_r[0]) begin
          y_nxt     = acc_r;
          state_nxt = mexp_pkg::S_MUL;
        end else begin
          y_nxt     = sq_r;
          state_nxt = mexp_pkg::S_SQR;
        end
      end

      mexp_pkg::S_MUL: begin
        p_nxt   = step_p;
        y_nxt   = {y_r[WIDTH-2:0], 1'b0};
        cnt_nxt = cnt_r - CW'(1);
        if (cnt_r == '0) begin
          acc_nxt   = step_p;
          p_nxt     = '0;
          y_nxt     = sq_r;
          cnt_nxt   = CW'(WIDTH - 1);
          state_nxt = mexp_pkg::S_SQR;
        end
      end

      mexp_pkg::S_SQR: begin
        p_nxt   = step_p;
        y_nxt   = {y_r[WIDTH-2:0], 1'b0};
        cnt_nxt = cnt_r - CW'(1);
        if (cnt_r == '0) begin
          sq_nxt    = step_p;
          exp_nxt   = {1'b0, exp_r[WIDTH-1:1]};
          state_nxt = mexp_pkg::S_CHK;
        end
      end

      default: begin
        state_nxt = mexp_pkg::S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mexp_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath, no reset needed
  always_ff @(posedge clk) begin
    m_r   <= m_nxt;
    sq_r  <= sq_nxt;
    acc_r <= acc_nxt;
    exp_r <= exp_nxt;
    p_r   <= p_nxt;
    y_r   <= y_nxt;
    cnt_r <= cnt_nxt;
    res_r <= res_nxt;
    err_r <= err_nxt;
  end

  assign busy              = (state_r != mexp_pkg::S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_power_result  = res_r;
  assign out_modulus_error = err_r;

  // An accepted word either starts a run or answers on the next cycle.
  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (busy || out_valid))
    else $error("accepted word neither started nor answered");

  // An error result always carries zero.
  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_modulus_error) |-> (out_power_result == '0))
    else $error("modulus error with nonzero result");

  // The accumulator multiply runs only for a set exponent bit.
  a_mul_bit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mexp_pkg::S_MUL) |-> exp_r[0])
    else $error("multiply on a clear exponent bit");

  // A normal result stays below the modulus, except the unreduced 1 for a zero exponent.
  a_result_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_modulus_error) |-> ((out_power_result < FW'(m_r)) ||
                                           (out_power_result == FW'(1))))
    else $error("result not reduced");

endmodule
